FILE: rtl/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg: shared definitions for the mpeg2 frame splitter
// Start code values, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package mfs_pkg;

  // default width of the frame byte counter
  localparam int unsigned LengthBitsDefault = 24;

  // width of the reported frame length field
  localparam int unsigned FrameLenBits = 24;

  // three-byte history and its reset pattern
  localparam int unsigned HistBits = 24;
  localparam logic [HistBits-1:0] HistReset  = 24'hFF_FFFF;
  localparam logic [HistBits-1:0] CodePrefix = 24'h00_0001;

  // start code low bytes
  localparam logic [7:0] CodeSeq   = 8'hB3;
  localparam logic [7:0] CodeGop   = 8'hB8;
  localparam logic [7:0] CodePic   = 8'h00;
  localparam logic [7:0] CodeSlice = 8'h01;
  localparam logic [7:0] CodeUser  = 8'hB2;
  localparam logic [7:0] CodeExt   = 8'hB5;

  // bytes of a start code, which open the next frame's count
  localparam int unsigned StartCodeBytes = 4;

endpackage : mfs_pkg

FILE: rtl/mpeg2_frame_splitter.sv
// ----------------------------------------------------------------------------
// mpeg2_frame_splitter: start code based frame splitter for mpeg2 video
// Counts elementary stream bytes per frame and reports each finished frame.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / stream_byte_i) takes one byte
//   of the elementary stream per transaction. The output channel
//   (out_valid_o / out_ready_i) carries one transaction per finished frame:
//   its byte length without the following start code, a saturation flag and
//   the low byte of the start code that opens the next frame.
//   A frame ends at a sequence, gop or picture start code that follows a
//   slice start code within the current frame.
//   Throughput is one byte per clock cycle unless a result stalls. A result
//   appears on the outputs in the cycle after the byte that completes it is
//   taken; the single output register is the only storage on the result path.
//   When the receiver stalls with a result pending, in_ready_o drops until
//   the result is taken; a result taken in the same cycle frees the register
//   for the next byte, so no cycle is lost.
//   Reset clears the byte history to all ones, the count to zero and all
//   frame flags; no result is pending after reset.
// ----------------------------------------------------------------------------
module mpeg2_frame_splitter #(
  parameter int unsigned LENGTH_BITS = mfs_pkg::LengthBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       stream_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mfs_pkg::FrameLenBits-1:0] frame_length_o,
  output logic                             length_saturated_o,
  output logic [7:0]                       next_code_o
);
  import mfs_pkg::*;

  localparam logic [LENGTH_BITS-1:0] CountMax   = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] CountStart = LENGTH_BITS'(StartCodeBytes);
  localparam logic [LENGTH_BITS-1:0] PrefixLag  = LENGTH_BITS'(3);

  logic [HistBits-1:0]     hist_q, hist_d;
  logic [LENGTH_BITS-1:0]  count_q, count_d;
  logic                    sat_q, sat_d;
  logic                    started_q, started_d;
  logic                    slice_q, slice_d;

  logic                    out_valid_q;
  logic [FrameLenBits-1:0] len_q, len_d;
  logic                    len_sat_q, len_sat_d;
  logic [7:0]              code_q;

  logic                    accept;
  logic                    prefix;
  logic                    frame_start;
  logic                    recognized;
  logic                    emit;
  logic [LENGTH_BITS-1:0]  count_inc;
  logic [LENGTH_BITS-1:0]  len_raw;
  logic [31:0]             len_wide;
  logic                    len_clip;

  // handshake: the output register frees up when its result is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // start code decode
  assign prefix      = (hist_q == CodePrefix);
  assign frame_start = prefix && ((stream_byte_i == CodeSeq) ||
                                  (stream_byte_i == CodeGop) ||
                                  (stream_byte_i == CodePic));
  assign recognized  = frame_start || (prefix && ((stream_byte_i == CodeSlice) ||
                                                  (stream_byte_i == CodeUser)  ||
                                                  (stream_byte_i == CodeExt)));
  assign emit        = frame_start && started_q && slice_q;

  // frame length of the finished frame, clipped to the output field
  assign count_inc = count_q + LENGTH_BITS'(1);
  always_comb begin
    if (sat_q) begin
      len_raw = CountMax;
    end else if (count_q >= PrefixLag) begin
      len_raw = count_q - PrefixLag;
    end else begin
      len_raw = '0;
    end
    len_wide = 32'(len_raw);
    len_clip = |len_wide[31:FrameLenBits];
    len_d     = len_clip ? {FrameLenBits{1'b1}} : len_wide[FrameLenBits-1:0];
    len_sat_d = sat_q || len_clip;
  end

  // next state of counter, flags and history
  always_comb begin
    count_d   = count_q;
    sat_d     = sat_q;
    started_d = started_q;
    slice_d   = slice_q;
    if (emit) begin
      count_d   = CountStart;
      sat_d     = 1'b0;
      slice_d   = 1'b0;
      started_d = 1'b1;
    end else begin
      if (count_q == CountMax) begin
        sat_d = 1'b1;
      end else begin
        count_d = count_inc;
        if (count_inc == CountMax) begin
          sat_d = 1'b1;
        end
      end
      if (frame_start) begin
        started_d = 1'b1;
      end
      if (prefix && (stream_byte_i == CodeSlice) && started_q) begin
        slice_d = 1'b1;
      end
    end
    hist_d = recognized ? HistReset : {hist_q[HistBits-9:0], stream_byte_i};
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= HistReset;
      count_q   <= '0;
      sat_q     <= 1'b0;
      started_q <= 1'b0;
      slice_q   <= 1'b0;
    end else if (accept) begin
      hist_q    <= hist_d;
      count_q   <= count_d;
      sat_q     <= sat_d;
      started_q <= started_d;
      slice_q   <= slice_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      len_q     <= len_d;
      len_sat_q <= len_sat_d;
      code_q    <= stream_byte_i;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign frame_length_o     = len_q;
  assign length_saturated_o = len_sat_q;
  assign next_code_o        = code_q;

  // a reported frame always ends at a frame start code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (next_code_o == CodeSeq) || (next_code_o == CodeGop) ||
                    (next_code_o == CodePic))
    else $error("result carries a code that is not a frame start");

  // a slice mark needs a frame start first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slice_q |-> started_q)
    else $error("slice mark set before any frame start");

  // after a frame is reported the new count holds the start code bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit) |=> (count_q == CountStart) && !slice_q && started_q && out_valid_q)
    else $error("frame restart did not reload the count");

  // a pending result that is not taken blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while a stalled result is pending");

endmodule : mpeg2_frame_splitter

FILE: tb/mpeg2_frame_splitter_test.sv
// ----------------------------------------------------------------------------
// mpeg2_frame_splitter_test: self-checking bench for the mpeg2 frame splitter
// Feeds elementary stream bytes through the valid/ready input, tracks start
// codes and frame byte counts in a local model, and compares every reported
// frame length, saturation flag and next start code with the model's list.
// ----------------------------------------------------------------------------
module mpeg2_frame_splitter_test;
  import mfs_pkg::*;

  localparam int unsigned CountBits = LengthBitsDefault;
  localparam logic [39:0] CountMax  = (40'd1 << CountBits) - 40'd1;
  localparam logic [39:0] OutMax    = (40'd1 << FrameLenBits) - 40'd1;
  // a start code low byte that the block does not know
  localparam logic [7:0] CodeUnknown = 8'h47;

  typedef struct packed {
    logic [FrameLenBits-1:0] length;
    logic                    saturated;
    logic [7:0]              code;
  } frame_result_t;

  // block ports
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [7:0]              stream_byte_i = 8'h00;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b1;
  logic [FrameLenBits-1:0] frame_length_o;
  logic                    length_saturated_o;
  logic [7:0]              next_code_o;

  // model state of the splitter
  logic [HistBits-1:0]  hist_bytes = HistReset;
  logic [CountBits-1:0] frame_bytes = '0;
  logic                 frame_sat = 1'b0;
  logic                 frame_open = 1'b0;
  logic                 slice_found = 1'b0;

  // frames awaited from the block, oldest first
  frame_result_t expected_frames[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_predicted = 0;
  int unsigned frames_checked = 0;
  int unsigned error_count = 0;

  mpeg2_frame_splitter uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .stream_byte_i      (stream_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .frame_length_o     (frame_length_o),
    .length_saturated_o (length_saturated_o),
    .next_code_o        (next_code_o)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_error(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // advance the frame model by one accepted byte
  task automatic track_byte(input logic [7:0] b);
    logic          prefix;
    logic          is_start;
    logic          known;
    logic [39:0]   len;
    frame_result_t res;
    prefix   = (hist_bytes == CodePrefix);
    is_start = prefix && (b == CodeSeq || b == CodeGop || b == CodePic);
    known    = is_start || (prefix && (b == CodeSlice || b == CodeUser || b == CodeExt));
    if (is_start && frame_open && slice_found) begin
      res.saturated = frame_sat;
      if (frame_sat) begin
        len = CountMax;
      end else begin
        len = (frame_bytes >= 3) ? 40'(frame_bytes) - 40'd3 : 40'd0;
      end
      if (len > OutMax) begin
        len = OutMax;
        res.saturated = 1'b1;
      end
      res.length = len[FrameLenBits-1:0];
      res.code = b;
      expected_frames.push_back(res);
      frames_predicted++;
      // the new start code opens the next frame's count
      frame_bytes = CountBits'(StartCodeBytes);
      frame_sat = 1'b0;
      slice_found = 1'b0;
      frame_open = 1'b1;
    end else begin
      if (40'(frame_bytes) >= CountMax) begin
        frame_bytes = CountMax[CountBits-1:0];
        frame_sat = 1'b1;
      end else begin
        frame_bytes++;
        if (40'(frame_bytes) == CountMax) frame_sat = 1'b1;
      end
      if (is_start) frame_open = 1'b1;
      if (prefix && b == CodeSlice && frame_open) slice_found = 1'b1;
    end
    hist_bytes = known ? HistReset : {hist_bytes[HistBits-9:0], b};
  endtask

  // one input transaction, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_start_code(input logic [7:0] code);
    send_byte(CodePrefix[23:16]);
    send_byte(CodePrefix[15:8]);
    send_byte(CodePrefix[7:0]);
    send_byte(code);
  endtask

  // payload leans on zeros and ones so stray prefixes show up
  task automatic send_payload(input int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_byte(8'h00);
        3:       send_byte(8'h01);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // random bytes, cut-off prefixes and unknown codes
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      1: begin
        send_byte(CodePrefix[23:16]);
        send_byte(CodePrefix[15:8]);
        send_byte(8'($urandom_range(2, 255)));
      end
      default: send_start_code(8'($urandom));
    endcase
  endtask

  // one well-formed frame with random headers and payload
  task automatic send_random_frame();
    if ($urandom_range(0, 3) == 0) begin
      send_start_code(CodeSeq);
      send_payload($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 0) begin
        send_start_code(CodeExt);
        send_payload($urandom_range(0, 3));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      send_start_code(CodeGop);
      send_payload($urandom_range(0, 4));
    end
    send_start_code(CodePic);
    send_payload($urandom_range(0, 5));
    if ($urandom_range(0, 4) == 0) begin
      send_start_code(CodeUser);
      send_payload($urandom_range(0, 3));
    end
    // now and then a frame with no slice, which keeps counting
    if ($urandom_range(0, 9) != 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_start_code(CodeSlice);
        send_payload($urandom_range(0, 8));
      end
    end
    if ($urandom_range(0, 6) == 0) send_noise();
  endtask

  // leading bytes, early slice and a frame start without a slice
  task automatic test_leading_bytes();
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_start_code(CodeSlice);
    send_start_code(CodeSeq);
    send_start_code(CodePic);
    send_start_code(CodeSlice);
    send_start_code(CodeGop);
  endtask

  // history clearing on known codes, unknown codes and runs of zeros
  task automatic test_code_overlap();
    send_start_code(CodePic);
    send_byte(CodePrefix[15:8]);
    send_byte(CodePrefix[7:0]);
    send_byte(CodeSeq);
    send_start_code(CodeUser);
    send_start_code(CodeExt);
    send_start_code(CodeUnknown);
    send_byte(8'h00);
    send_start_code(CodeSlice);
    send_byte(8'h80);
    send_start_code(CodeSeq);
  endtask

  // random streams under one flow-control setting
  task automatic test_random_streams(input int unsigned gap_pct, input int unsigned hold_pct,
                                     input int unsigned n_bytes);
    int unsigned first_byte;
    send_idle_pct = gap_pct;
    stall_pct = hold_pct;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < n_bytes) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_random_frame();
    end
  endtask

  // compare each output transaction with the oldest awaited frame
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_frames.size() == 0) begin
        report_error($sformatf("unexpected frame length %0d code %02h",
                               frame_length_o, next_code_o));
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        if (frame_length_o !== want.length)
          report_error($sformatf("frame_length got %0d expected %0d",
                                 frame_length_o, want.length));
        if (length_saturated_o !== want.saturated)
          report_error($sformatf("length_saturated got %b expected %b",
                                 length_saturated_o, want.saturated));
        if (next_code_o !== want.code)
          report_error($sformatf("next_code got %02h expected %02h",
                                 next_code_o, want.code));
      end
    end
  end

  // run limit
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // test sequence
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_leading_bytes();
    test_code_overlap();
    test_random_streams(0, 0, 160);
    test_random_streams(56, 0, 160);
    test_random_streams(0, 56, 160);
    test_random_streams(34, 34, 160);
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_frames.size() != 0)
      report_error($sformatf("%0d frames never reported", expected_frames.size()));
    $display("sent %0d stream bytes, predicted %0d frames, checked %0d frames",
             bytes_sent, frames_predicted, frames_checked);
    $display("phases: free flow, sender gaps, receiver stalls, both");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : mpeg2_frame_splitter_test
